[rtl/core/assert_macros.svh]
// shared assertion macros, compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent at the next clock edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/mfb_pkg.sv]
`timescale 1ns / 1ps
package mfb_pkg;

  localparam int unsigned FrameRows    = 64;
  localparam int unsigned FrameColumns = 128;
  localparam int unsigned BytesPerRow  = FrameColumns / 8;
  localparam int unsigned RowAddrW     = $clog2(FrameRows);
  localparam int unsigned ByteIdxW     = $clog2(BytesPerRow);

  localparam logic [7:0] AddrCmd = 8'h80;

  typedef enum logic [2:0] {
    CmdPixel   = 3'd0,
    CmdHRun    = 3'd1,
    CmdVRun    = 3'd2,
    CmdClear   = 3'd3,
    CmdRefresh = 3'd4
  } cmd_e;

  typedef logic [BytesPerRow-1:0][7:0] line_t;

endpackage

[rtl/core/mfb_ram.sv]
`timescale 1ns / 1ps
module mfb_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/mono_framebuffer_draw_refresh.sv]
`timescale 1ns / 1ps
// 128x64 monochrome frame store with drawing commands and row refresh.
// input channel: one command transfer carries command, row, column,
//   end_position and color; in_stall_o is high while a command is in work.
// output channel: only a refresh row produces transfers, 32 of them: per
//   column pair a page byte, a column byte, then two data bytes (is_data_o
//   high); last_o marks the final data byte.
// steps: a pixel or horizontal run reads the row, then modifies and writes
//   it back; a vertical run repeats that read and modify-write for each row
//   drawn; a clear needs no memory access (per-row valid bits drop at once);
//   a refresh fetches the row into the line buffer, then sends one byte per
//   cycle while the receiver does not stall. the frame memory's read and
//   write ports share one row address, and the line buffer holds one row.
// out-of-range coordinates and unused command codes are dropped silently.
// reset: every row reads as blank afterwards; no sweep of the memory.
// stall: a stalled output transfer holds its byte; the line buffer waits,
//   and once the last byte sits in the output register a new command is
//   taken while that byte is still waiting.
module mono_framebuffer_draw_refresh (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] row_i,
  input  logic [7:0] column_i,
  input  logic [7:0] end_position_i,
  input  logic       color_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_data_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);
  import mfb_pkg::*;

  `include "assert_macros.svh"

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRead   = 2'd1;
  localparam logic [1:0] StModify = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0]          state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [7:0]          row_q, row_d;
  logic [7:0]          col_q, col_d;
  logic [7:0]          end_q, end_d;
  logic                color_q, color_d;
  logic [FrameRows-1:0] valid_q, valid_d;   // row has been written since clear
  line_t               line_q, line_d;      // row held for refresh
  logic [4:0]          idx_q, idx_d;        // refresh byte counter

  logic                out_valid_q, out_valid_d;
  logic                out_is_data_q, out_is_data_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  logic                  ram_we, ram_re;
  logic [FrameColumns-1:0] ram_wdata, ram_rdata, cur_row, run_mask;
  logic                  accept, out_load;
  cmd_e                  in_cmd;
  logic [7:0]            next_row;
  logic [2:0]            pair;
  logic [ByteIdxW-1:0]   byte_idx;

  mfb_ram #(
    .Width(FrameColumns),
    .Depth(FrameRows)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row_q[RowAddrW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(row_q[RowAddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_cmd     = cmd_e'(command_i);
  assign out_load   = !out_valid_q || !out_stall_i;

  // a row never written since the last clear reads as blank
  assign cur_row  = valid_q[row_q[RowAddrW-1:0]] ? ram_rdata : '0;
  assign next_row = row_q + 8'd1;

  // column c lives at bit FrameColumns-1-c, so bit 7 of a byte is leftmost
  always_comb begin
    for (int j = 0; j < FrameColumns; j++) begin
      run_mask[FrameColumns-1-j] = (8'(j) >= col_q) && (8'(j) < end_q);
    end
  end

  assign pair     = idx_q[4:2];
  assign byte_idx = {pair, idx_q[0]};

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    row_d         = row_q;
    col_d         = col_q;
    end_d         = end_q;
    color_d       = color_q;
    valid_d       = valid_q;
    line_d        = line_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_is_data_d = out_is_data_q;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = cur_row;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_d   = in_cmd;
          row_d   = row_i;
          col_d   = column_i;
          end_d   = end_position_i;
          color_d = color_i;
          unique case (in_cmd) inside
            CmdPixel: begin
              if (row_i < 8'(FrameRows) && column_i < 8'(FrameColumns)) begin
                state_d = StRead;
              end
            end
            CmdHRun, CmdRefresh: begin
              if (row_i < 8'(FrameRows)) begin
                state_d = StRead;
              end
            end
            CmdVRun: begin
              if (column_i < 8'(FrameColumns) && row_i < end_position_i &&
                  row_i < 8'(FrameRows)) begin
                state_d = StRead;
              end
            end
            CmdClear: begin
              valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        ram_re  = 1'b1;
        state_d = StModify;
      end
      StModify: begin
        unique case (cmd_q)
          CmdPixel: begin
            ram_we = 1'b1;
            ram_wdata[FrameColumns-1-int'(col_q[6:0])] = color_q;
            valid_d[row_q[RowAddrW-1:0]] = 1'b1;
            state_d = StIdle;
          end
          CmdHRun: begin
            ram_we    = 1'b1;
            ram_wdata = cur_row | run_mask;
            valid_d[row_q[RowAddrW-1:0]] = 1'b1;
            state_d   = StIdle;
          end
          CmdVRun: begin
            ram_we = 1'b1;
            ram_wdata[FrameColumns-1-int'(col_q[6:0])] = 1'b1;
            valid_d[row_q[RowAddrW-1:0]] = 1'b1;
            row_d = next_row;
            if (next_row < end_q && next_row < 8'(FrameRows)) begin
              state_d = StRead;
            end else begin
              state_d = StIdle;
            end
          end
          CmdRefresh: begin
            line_d  = line_t'(cur_row);
            idx_d   = '0;
            state_d = StEmit;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          case (idx_q[1:0])
            2'd0: begin
              out_is_data_d = 1'b0;
              out_byte_d    = AddrCmd | {3'b000, row_q[4:0]};
            end
            2'd1: begin
              out_is_data_d = 1'b0;
              out_byte_d    = AddrCmd + {4'b0000, row_q[5], pair};
            end
            default: begin
              out_is_data_d = 1'b1;
              out_byte_d    = line_q[~byte_idx];
              out_last_d    = (idx_q == 5'd31);
            end
          endcase
          idx_d = idx_q + 5'd1;
          if (idx_q == 5'd31) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cmd_q       <= CmdPixel;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cmd_q       <= cmd_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    row_q         <= row_d;
    col_q         <= col_d;
    end_q         <= end_d;
    color_q       <= color_d;
    line_q        <= line_d;
    out_is_data_q <= out_is_data_d;
    out_byte_q    <= out_byte_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = out_is_data_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

  // the final byte of a refresh is always a data byte
  `ASSERT_AT(a_last_is_data, clk_i, rst_ni,
             !(out_valid_q && out_last_q) || out_is_data_q)
  // a write marks its row valid, so it reads back as stored data until a clear
  `ASSERT_NEXT(a_write_marks_valid, clk_i, rst_ni, ram_we,
               valid_q[$past(row_q[RowAddrW-1:0])])
  // only a refresh streams bytes
  `ASSERT_AT(a_emit_is_refresh, clk_i, rst_ni,
             state_q != StEmit || cmd_q == CmdRefresh)

endmodule

[tb/tb_mono_framebuffer_draw_refresh.sv]
`timescale 1ns / 1ps
import mfb_pkg::*;

// keeps its own copy of the frame store and the queue of display writes
// that each refresh row must produce, in order
class lcd_write_scoreboard;
  typedef struct packed {
    logic       is_data;
    logic [7:0] data;
    logic       last;
  } lcd_write_t;

  localparam int unsigned HalfRows        = 32;
  localparam int unsigned PairsPerRow     = BytesPerRow / 2;
  localparam logic [7:0]  LowerHalfOffset = 8'h08;
  localparam int unsigned MaxReports      = 50;

  logic [7:0]  frame [FrameRows][BytesPerRow];
  lcd_write_t  expected_writes [$];
  int unsigned error_count;
  int unsigned write_count;
  int unsigned refresh_count;
  int unsigned command_count;

  function new();
    clear_frame();
  endfunction

  function void clear_frame();
    foreach (frame[r, b]) frame[r][b] = 8'h00;
  endfunction

  // bit 7 of a stored byte is the leftmost pixel
  function void put_pixel(int r, int c, logic on);
    logic [7:0] mask;
    mask = 8'h80 >> (c % 8);
    if (on) frame[r][c / 8] = frame[r][c / 8] | mask;
    else frame[r][c / 8] = frame[r][c / 8] & ~mask;
  endfunction

  function int pending();
    return expected_writes.size();
  endfunction

  // one accepted command transfer
  function void note_command(logic [2:0] cmd, logic [7:0] r, logic [7:0] c,
                             logic [7:0] e, logic color);
    int         i;
    int         p;
    logic [7:0] half;
    lcd_write_t w;
    command_count++;
    case (cmd)
      CmdPixel: begin
        if (r < FrameRows && c < FrameColumns) put_pixel(r, c, color);
      end
      CmdHRun: begin
        if (r < FrameRows)
          for (i = c; i < e && i < FrameColumns; i++) put_pixel(r, i, 1'b1);
      end
      CmdVRun: begin
        if (c < FrameColumns)
          for (i = r; i < e && i < FrameRows; i++) put_pixel(i, c, 1'b1);
      end
      CmdClear: begin
        clear_frame();
      end
      CmdRefresh: begin
        if (r < FrameRows) begin
          refresh_count++;
          half = (r >= HalfRows) ? LowerHalfOffset : 8'h00;
          for (p = 0; p < PairsPerRow; p++) begin
            w = '{1'b0, AddrCmd | 8'(r % HalfRows), 1'b0};
            expected_writes.push_back(w);
            w = '{1'b0, AddrCmd + (8'(p) | half), 1'b0};
            expected_writes.push_back(w);
            w = '{1'b1, frame[r][2 * p], 1'b0};
            expected_writes.push_back(w);
            w = '{1'b1, frame[r][2 * p + 1], (p == PairsPerRow - 1)};
            expected_writes.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void mismatch(string field, logic [7:0] want, logic [7:0] got);
    error_count++;
    if (error_count <= MaxReports)
      $error("%s mismatch: expected %02h, actual %02h", field, want, got);
  endfunction

  // one accepted output transfer, compared with the oldest expected write
  function void check_write(logic is_data, logic [7:0] data, logic last);
    lcd_write_t w;
    write_count++;
    if (expected_writes.size() == 0) begin
      error_count++;
      if (error_count <= MaxReports)
        $error("unexpected write: is_data %0b out_byte %02h last %0b",
               is_data, data, last);
      return;
    end
    w = expected_writes.pop_front();
    if (is_data !== w.is_data) mismatch("is_data", 8'(w.is_data), 8'(is_data));
    if (data !== w.data) mismatch("out_byte", w.data, data);
    if (last !== w.last) mismatch("last", 8'(w.last), 8'(last));
  endfunction
endclass

module tb_mono_framebuffer_draw_refresh;

  // spare command codes the block must ignore
  localparam logic [2:0]  CmdSpareLo  = 3'd5;
  localparam logic [2:0]  CmdSpareHi  = 3'd7;
  localparam int          RandomItems = 160;
  // slowest run: ~190 commands, each a full refresh under heavy stall plus
  // a full-height vertical run and the longest sender gap, well under the limit
  localparam int unsigned CycleLimit  = 600000;
  // longest command is a full-height vertical run
  localparam int          DrainCycles = 200;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy
  } stall_mode_e;

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [2:0] command_i      = 3'd0;
  logic [7:0] row_i          = 8'd0;
  logic [7:0] column_i       = 8'd0;
  logic [7:0] end_position_i = 8'd0;
  logic       color_i        = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic       is_data_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  lcd_write_scoreboard sb;
  int unsigned         cycle_count     = 0;
  int                  burst_left      = 0;
  stall_mode_e         stall_mode      = StallNone;
  int                  stall_mode_left = 0;

  mono_framebuffer_draw_refresh dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .end_position_i (end_position_i),
    .color_i        (color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_data_o      (is_data_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a lost write ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: checks every output transfer, then picks the next stall
  // value; the stall pattern switches at random between free-running, light
  // and heavy stalling so stalls land on every byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_write(is_data_o, out_byte_o, last_o);
    if (stall_mode_left == 0) begin
      stall_mode      <= stall_mode_e'($urandom_range(0, 2));
      stall_mode_left <= $urandom_range(20, 120);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 7) != 0);
      default:    out_stall_i <= 1'b0;
    endcase
  end

  // sender lowers valid and idles, with n at least one, so valid is never lowered
  // and raised in the same step
  task automatic idle(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold off new commands until every expected display write has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // present one command and hold it until the transfer happens; the
  // sender works in bursts with random gaps between them
  task automatic send(input logic [2:0] cmd, input logic [7:0] r,
                      input logic [7:0] c, input logic [7:0] e,
                      input logic color);
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    row_i          <= r;
    column_i       <= c;
    end_position_i <= e;
    color_i        <= color;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_command(cmd, r, c, e, color);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int         pick;
    int         valid_items;
    int         span;
    logic [2:0] cmd;
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] e;
    logic       color;

    sb = new();
    valid_items = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: store must read blank after reset
    send(CmdRefresh, 8'd0, 8'd0, 8'd0, 1'b0);
    // corner pixels, then pixels just off each edge and at the field maxima
    send(CmdPixel, 8'd0, 8'd0, 8'd0, 1'b1);
    send(CmdPixel, 8'd63, 8'd127, 8'd0, 1'b1);
    send(CmdPixel, 8'd64, 8'd5, 8'd0, 1'b1);
    send(CmdPixel, 8'd10, 8'd128, 8'd0, 1'b1);
    send(CmdPixel, 8'd255, 8'd255, 8'd255, 1'b1);
    // horizontal run past the right edge, color low must still set pixels
    send(CmdHRun, 8'd5, 8'd3, 8'd255, 1'b0);
    // empty and reversed runs, run on a row off the bottom
    send(CmdHRun, 8'd6, 8'd40, 8'd40, 1'b1);
    send(CmdHRun, 8'd6, 8'd50, 8'd20, 1'b1);
    send(CmdHRun, 8'd64, 8'd0, 8'd128, 1'b1);
    // vertical run in the last column past the bottom edge, one off the right edge, an empty one
    send(CmdVRun, 8'd0, 8'd127, 8'd255, 1'b0);
    send(CmdVRun, 8'd2, 8'd128, 8'd50, 1'b1);
    send(CmdVRun, 8'd20, 8'd9, 8'd20, 1'b1);
    // clear a pixel again
    send(CmdPixel, 8'd0, 8'd0, 8'd0, 1'b0);
    // refresh across both halves of the panel
    send(CmdRefresh, 8'd0, 8'd0, 8'd0, 1'b0);
    send(CmdRefresh, 8'd5, 8'd0, 8'd0, 1'b1);
    send(CmdRefresh, 8'd31, 8'd0, 8'd0, 1'b0);
    send(CmdRefresh, 8'd32, 8'd0, 8'd0, 1'b0);
    send(CmdRefresh, 8'd63, 8'd0, 8'd0, 1'b0);
    // refresh off the bottom gives no writes
    send(CmdRefresh, 8'd255, 8'd255, 8'd255, 1'b1);
    // spare codes change nothing
    send(CmdSpareLo, 8'd3, 8'd3, 8'd200, 1'b1);
    send(3'(CmdSpareLo + 3'd1), 8'd4, 8'd4, 8'd200, 1'b1);
    send(CmdSpareHi, 8'd5, 8'd5, 8'd200, 1'b1);
    // full clear, then a row that had pixels set
    send(CmdClear, 8'd0, 8'd0, 8'd0, 1'b0);
    send(CmdRefresh, 8'd63, 8'd0, 8'd0, 1'b0);

    drain();

    // random: mostly in-range drawing and refreshes, with some
    // out-of-range coordinates, rare clears and rare spare codes
    while (valid_items < RandomItems) begin
      pick  = $urandom_range(0, 99);
      color = 1'($urandom_range(0, 1));
      e     = 8'($urandom_range(0, 255));
      if (pick < 28) begin
        cmd = CmdPixel;
        r   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 63));
        c   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 127));
      end else if (pick < 48) begin
        cmd  = CmdHRun;
        r    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 63));
        c    = 8'($urandom_range(0, 127));
        span = c + $urandom_range(0, 40);
        if ($urandom_range(0, 4) != 0) e = (span > 255) ? 8'hFF : 8'(span);
      end else if (pick < 63) begin
        cmd  = CmdVRun;
        c    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
        r    = 8'($urandom_range(0, 63));
        span = r + $urandom_range(0, 12);
        if ($urandom_range(0, 4) != 0) e = 8'(span);
      end else if (pick < 93) begin
        cmd = CmdRefresh;
        r   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 63));
        c   = 8'($urandom_range(0, 255));
      end else if (pick < 96) begin
        cmd = CmdClear;
        r   = 8'($urandom_range(0, 255));
        c   = 8'($urandom_range(0, 255));
      end else begin
        cmd = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
        r   = 8'($urandom_range(0, 255));
        c   = 8'($urandom_range(0, 255));
      end
      send(cmd, r, c, e, color);
      if (cmd <= CmdRefresh) valid_items++;
      // halfway through, let the display side run completely dry
      if (valid_items == RandomItems / 2) drain();
    end

    // wind down: all writes in, then a quiet stretch to catch strays
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d commands, %0d refresh rows, %0d display writes checked",
             sb.command_count, sb.refresh_count, sb.write_count);
    $display("run: %0d mismatches under random sender gaps and receiver stalls",
             sb.error_count);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
